// ----- rtl/core/abmsd_pkg.sv -----
package abmsd_pkg;

  localparam int ADDR_W       = 13;
  localparam int STORE_DEPTH  = 6912;
  localparam int LINES        = 192;
  localparam int PIXELS       = 8;
  localparam int COLOR_W      = 16;

  localparam int CMDQ_DEPTH   = 2;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH   = 4;
  localparam int OUTQ_PTR_W   = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

  // command field codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic {
    OP_WRITE,
    OP_FETCH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;       // write address or bitmap address
    logic [ADDR_W-1:0] attr_addr;
    logic [7:0]        wdata;
    logic [7:0]        scanline;
    logic [4:0]        column;
  } cmd_t;

  typedef struct packed {
    logic [PIXELS-1:0][COLOR_W-1:0] pixels;  // pixels[0] is leftmost
    logic [7:0]                     scanline;
    logic [4:0]                     column;
  } result_t;

  localparam logic [COLOR_W-1:0] PALETTE [16] = '{
    16'h0000, 16'h0018, 16'hC000, 16'hC018,
    16'h0600, 16'h0618, 16'hC600, 16'hC618,
    16'h0000, 16'h001F, 16'hF800, 16'hF81F,
    16'h07E0, 16'h07FF, 16'hFFE0, 16'hFFFF
  };

endpackage

// ----- rtl/core/abmsd_ram.sv -----
module abmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/abmsd_front.sv -----
module abmsd_front
  import abmsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [ADDR_W-1:0] write_address,
  input  logic [7:0]        write_byte,
  input  logic [7:0]        scanline,
  input  logic [4:0]        column,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_ready
);

  cmd_t                  entry;
  logic                  entry_ok;
  logic                  enq;
  logic                  deq;
  cmd_t                  queue [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;

  // classify the word and form store addresses
  always_comb begin
    entry.op        = (command == CMD_FETCH) ? OP_FETCH : OP_WRITE;
    entry.attr_addr = {2'b11, 1'b0, scanline[7:3], column};
    entry.addr      = (command == CMD_FETCH)
                      ? {scanline[7:6], scanline[2:0], scanline[5:3], column}
                      : write_address;
    entry.wdata     = write_byte;
    entry.scanline  = scanline;
    entry.column    = column;
    entry_ok        = (command == CMD_WRITE)
                      ? (write_address < ADDR_W'(STORE_DEPTH))
                      : (scanline < 8'(LINES));
  end

  assign full      = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  // drop out-of-range words here
  assign enq       = push && !full && entry_ok;
  assign deq       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (enq) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + CMDQ_PTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + CMDQ_PTR_W'(1);
      end
      if (enq && !deq) begin
        count <= count + CMDQ_CNT_W'(1);
      end else if (deq && !enq) begin
        count <= count - CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/abmsd_back.sv -----
module abmsd_back
  import abmsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_ready,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic                  take;
  logic                  credit;
  logic                  rd_valid;
  logic [7:0]            rd_scanline;
  logic [4:0]            rd_column;
  logic [7:0]            bits;
  logic [7:0]            attr;
  logic [COLOR_W-1:0]    ink_color;
  logic [COLOR_W-1:0]    paper_color;
  result_t               fresh;
  result_t               outq [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_CNT_W-1:0] count;
  logic                  deq;

  // hold a fetch until the result queue has room for it and any read in flight
  assign credit    = ((OUTQ_CNT_W + 1)'(count) + (OUTQ_CNT_W + 1)'(rd_valid))
                     < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);
  assign cmd_ready = (cmd.op == OP_WRITE) || credit;
  assign take      = cmd_valid && cmd_ready;

  abmsd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (take && (cmd.op == OP_WRITE)),
    .waddr   (cmd.addr),
    .wdata   (cmd.wdata),
    .raddr_a (cmd.addr),
    .rdata_a (bits),
    .raddr_b (cmd.attr_addr),
    .rdata_b (attr)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      rd_scanline <= cmd.scanline;
      rd_column   <= cmd.column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= take && (cmd.op == OP_FETCH);
    end
  end

  // ink takes bright as its top bit, paper is bits 6..3
  always_comb begin
    ink_color      = PALETTE[{attr[6], attr[2:0]}];
    paper_color    = PALETTE[attr[6:3]];
    fresh.scanline = rd_scanline;
    fresh.column   = rd_column;
    for (int k = 0; k < PIXELS; k++) begin
      fresh.pixels[k] = bits[PIXELS-1-k] ? ink_color : paper_color;
    end
  end

  assign empty  = (count == '0);
  assign result = outq[rd_ptr];
  assign deq    = pop && !empty;

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      outq[wr_ptr] <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (rd_valid) begin
        wr_ptr <= wr_ptr + OUTQ_PTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      if (rd_valid && !deq) begin
        count <= count + OUTQ_CNT_W'(1);
      end else if (deq && !rd_valid) begin
        count <= count - OUTQ_CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/attribute_bitmap_screen_decoder_unit.sv -----
// Screen decoder: holds a 6912-byte screen (6144 bitmap bytes in thirds, then
// 768 attribute bytes). A write word stores one byte; a fetch word gives eight
// RGB565 pixels for one scanline and character column. Writes to addresses
// 6912 and up and fetches of scanline 192 and up are dropped. Words are taken
// at one per cycle sustained while no fetch stalls, and are executed in order;
// a fetch passes through the two-entry command queue and the registered read
// of the dual-port screen store, which reads bitmap and attribute bytes in the
// same cycle, into the result queue. Four results can wait before fetches
// stall; a stalled fetch also holds back every word queued behind it.
// Fetching a byte that was never written returns undefined pixels.
module attribute_bitmap_screen_decoder_unit
  import abmsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               command,
  input  logic [ADDR_W-1:0]  write_address,
  input  logic [7:0]         write_byte,
  input  logic [7:0]         scanline,
  input  logic [4:0]         column,
  output logic               empty,
  input  logic               pop,
  output logic [COLOR_W-1:0] pixel_0,
  output logic [COLOR_W-1:0] pixel_1,
  output logic [COLOR_W-1:0] pixel_2,
  output logic [COLOR_W-1:0] pixel_3,
  output logic [COLOR_W-1:0] pixel_4,
  output logic [COLOR_W-1:0] pixel_5,
  output logic [COLOR_W-1:0] pixel_6,
  output logic [COLOR_W-1:0] pixel_7,
  output logic [7:0]         out_scanline,
  output logic [4:0]         out_column
);

  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  result_t result;

  abmsd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .write_address (write_address),
    .write_byte    (write_byte),
    .scanline      (scanline),
    .column        (column),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_ready     (cmd_ready)
  );

  abmsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign pixel_0      = result.pixels[0];
  assign pixel_1      = result.pixels[1];
  assign pixel_2      = result.pixels[2];
  assign pixel_3      = result.pixels[3];
  assign pixel_4      = result.pixels[4];
  assign pixel_5      = result.pixels[5];
  assign pixel_6      = result.pixels[6];
  assign pixel_7      = result.pixels[7];
  assign out_scanline = result.scanline;
  assign out_column   = result.column;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import abmsd_pkg::*;

  localparam int BITMAP_BYTES = 6144;
  localparam int ITEMS        = 1550;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 120;
  localparam int DRAIN_CYCLES = 16;

  class screen_scoreboard;
    logic [7:0] screen_copy [STORE_DEPTH];
    bit         written [STORE_DEPTH];
    result_t    pending_groups [$];
    int         errors;
    int         groups_checked;
    int         bytes_stored;
    int         writes_dropped;
    int         fetches_dropped;

    function int bitmap_addr(logic [7:0] line, logic [4:0] col);
      return int'(line[7:6]) * 2048 + int'(line[2:0]) * 256 + int'(line[5:3]) * 32 + int'(col);
    endfunction

    function int attr_addr(logic [7:0] line, logic [4:0] col);
      return BITMAP_BYTES + int'(line[7:3]) * 32 + int'(col);
    endfunction

    // bit 0 blue, bit 1 red, bit 2 green, bit 3 picks the bright level
    function logic [15:0] rgb565(logic [3:0] idx);
      logic [7:0] lvl;
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      lvl = idx[3] ? 8'd255 : 8'd192;
      r = idx[1] ? lvl[7:3] : 5'd0;
      g = idx[2] ? lvl[7:2] : 6'd0;
      b = idx[0] ? lvl[7:3] : 5'd0;
      return {r, g, b};
    endfunction

    function result_t decode_group(logic [7:0] line, logic [4:0] col);
      result_t    grp;
      logic [7:0] bits;
      logic [7:0] attr;
      logic [15:0] ink_c;
      logic [15:0] paper_c;
      int         k;
      bits    = screen_copy[bitmap_addr(line, col)];
      attr    = screen_copy[attr_addr(line, col)];
      ink_c   = rgb565({attr[6], attr[2:0]});
      paper_c = rgb565(attr[6:3]);
      for (k = 0; k < PIXELS; k++)
        grp.pixels[k] = bits[7-k] ? ink_c : paper_c;
      grp.scanline = line;
      grp.column   = col;
      return grp;
    endfunction

    // Returns 1 when the word has an effect on the block.
    function bit note_word(logic cmd, logic [ADDR_W-1:0] addr, logic [7:0] data,
                           logic [7:0] line, logic [4:0] col);
      if (cmd == CMD_WRITE) begin
        if (addr < STORE_DEPTH) begin
          screen_copy[addr] = data;
          written[addr]     = 1'b1;
          bytes_stored++;
          return 1'b1;
        end
        writes_dropped++;
        return 1'b0;
      end
      if (line >= LINES) begin
        fetches_dropped++;
        return 1'b0;
      end
      pending_groups.push_back(decode_group(line, col));
      return 1'b1;
    endfunction

    function void check_group(result_t got);
      result_t want;
      int      k;
      if (pending_groups.size() == 0) begin
        $error("unexpected pixel group: scanline %0d column %0d", got.scanline, got.column);
        errors++;
        return;
      end
      want = pending_groups.pop_front();
      for (k = 0; k < PIXELS; k++)
        if (got.pixels[k] !== want.pixels[k]) begin
          $error("pixel_%0d: expected %h, got %h", k, want.pixels[k], got.pixels[k]);
          errors++;
        end
      if (got.scanline !== want.scanline) begin
        $error("out_scanline: expected %0d, got %0d", want.scanline, got.scanline);
        errors++;
      end
      if (got.column !== want.column) begin
        $error("out_column: expected %0d, got %0d", want.column, got.column);
        errors++;
      end
      groups_checked++;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               command = CMD_WRITE;
  logic [ADDR_W-1:0]  write_address = '0;
  logic [7:0]         write_byte = '0;
  logic [7:0]         scanline = '0;
  logic [4:0]         column = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [COLOR_W-1:0] pixel_0, pixel_1, pixel_2, pixel_3;
  logic [COLOR_W-1:0] pixel_4, pixel_5, pixel_6, pixel_7;
  logic [7:0]         out_scanline;
  logic [4:0]         out_column;

  screen_scoreboard sb = new();
  int  fed = 0;
  int  cycles = 0;
  bit  feed_burst = 1'b0;
  int  ready_cells [$];

  attribute_bitmap_screen_decoder_unit dut (
    .clk, .rst, .push, .full, .command, .write_address, .write_byte,
    .scanline, .column, .empty, .pop,
    .pixel_0, .pixel_1, .pixel_2, .pixel_3, .pixel_4, .pixel_5, .pixel_6, .pixel_7,
    .out_scanline, .out_column
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout with %0d pixel groups outstanding", sb.pending_groups.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_word(input logic cmd, input logic [ADDR_W-1:0] addr,
                           input logic [7:0] data, input logic [7:0] line,
                           input logic [4:0] col);
    int gap;
    if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
    gap = feed_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    command       <= cmd;
    write_address <= addr;
    write_byte    <= data;
    scanline      <= line;
    column        <= col;
    @(posedge clk);
    while (full) @(posedge clk);
    void'(sb.note_word(cmd, addr, data, line, col));
    fed++;
  endtask

  // unused fields carry noise
  task automatic store_byte(input logic [ADDR_W-1:0] addr, input logic [7:0] data);
    push_word(CMD_WRITE, addr, data, 8'($urandom), 5'($urandom));
  endtask

  task automatic fetch_group(input logic [7:0] line, input logic [4:0] col);
    push_word(CMD_FETCH, ADDR_W'($urandom), 8'($urandom), line, col);
  endtask

  // Fill in whatever the cell still lacks so a fetch never reads an unwritten byte.
  task automatic prime_cell(input logic [7:0] line, input logic [4:0] col);
    if (!sb.written[sb.bitmap_addr(line, col)])
      store_byte(ADDR_W'(sb.bitmap_addr(line, col)), 8'($urandom));
    if (!sb.written[sb.attr_addr(line, col)])
      store_byte(ADDR_W'(sb.attr_addr(line, col)), 8'($urandom));
    ready_cells.push_back(int'(line) * 32 + int'(col));
  endtask

  initial begin
    int          pick;
    int          slot;
    logic [7:0]  line;
    logic [4:0]  col;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // corners of the screen, palette extremes, dropped words
    store_byte(ADDR_W'(0), 8'hA5);
    store_byte(ADDR_W'(BITMAP_BYTES), 8'h00);
    fetch_group(8'd0, 5'd0);
    store_byte(ADDR_W'(BITMAP_BYTES), 8'hFF);
    fetch_group(8'd0, 5'd0);
    store_byte(ADDR_W'(BITMAP_BYTES), 8'h38);
    fetch_group(8'd0, 5'd0);
    store_byte(ADDR_W'(BITMAP_BYTES - 1), 8'h0F);
    store_byte(ADDR_W'(STORE_DEPTH - 1), 8'h47);
    fetch_group(8'd191, 5'd31);
    store_byte(ADDR_W'(STORE_DEPTH), 8'h55);
    store_byte(ADDR_W'(8191), 8'hAA);
    fetch_group(8'd191, 5'd31);
    fetch_group(8'd192, 5'd5);
    fetch_group(8'd255, 5'd31);
    store_byte(ADDR_W'(BITMAP_BYTES - 1), 8'hFF);
    store_byte(ADDR_W'(STORE_DEPTH - 1), 8'h00);
    fetch_group(8'd191, 5'd31);
    ready_cells.push_back(0);
    ready_cells.push_back(191 * 32 + 31);
    prime_cell(8'd73, 5'd16);
    fetch_group(8'd73, 5'd16);

    while (fed < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        line = 8'($urandom_range(0, LINES - 1));
        col  = 5'($urandom);
        prime_cell(line, col);
        if ($urandom_range(0, 2) == 0)
          store_byte(ADDR_W'(sb.attr_addr(line, col)), 8'($urandom));
        if ($urandom_range(0, 2) == 0)
          store_byte(ADDR_W'(sb.bitmap_addr(line, col)), 8'($urandom));
        fetch_group(line, col);
      end else if (pick < 65) begin
        slot = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
        fetch_group(8'(slot / 32), 5'(slot % 32));
      end else if (pick < 88) begin
        store_byte(ADDR_W'($urandom_range(0, 8191)), 8'($urandom));
      end else begin
        fetch_group(8'($urandom_range(LINES, 255)), 5'($urandom));
      end
    end
    push <= 1'b0;

    while (sb.pending_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Stored %0d screen bytes, dropped %0d out-of-range writes and %0d fetches,",
             sb.bytes_stored, sb.writes_dropped, sb.fetches_dropped);
    $display("checked %0d pixel groups, including a %0d-cycle stall on the result side.",
             sb.groups_checked, HOLD_CYCLES);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int      idle;
    bit      held;
    bit      drain_burst;
    result_t got;
    held        = 1'b0;
    drain_burst = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
      idle = drain_burst ? 0 : $urandom_range(0, 12);
      // hold off once so the result side backs up into the input
      if (!held && sb.groups_checked >= HOLD_AFTER) begin
        held = 1'b1;
        idle += HOLD_CYCLES;
      end
      if (idle > 0) begin
        pop <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.pixels[0] = pixel_0;
      got.pixels[1] = pixel_1;
      got.pixels[2] = pixel_2;
      got.pixels[3] = pixel_3;
      got.pixels[4] = pixel_4;
      got.pixels[5] = pixel_5;
      got.pixels[6] = pixel_6;
      got.pixels[7] = pixel_7;
      got.scanline  = out_scanline;
      got.column    = out_column;
      sb.check_group(got);
    end
  end

endmodule

// ----- files.f -----
rtl/core/abmsd_pkg.sv
rtl/core/abmsd_ram.sv
rtl/core/abmsd_front.sv
rtl/core/abmsd_back.sv
rtl/core/attribute_bitmap_screen_decoder_unit.sv
tb/sv/tb_top.sv
